>>> rtl/bir_pkg.sv
package bir_pkg;

    // Field widths fixed by the stream format.
    localparam int POS_W      = 9;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIXEL_W    = NUM_CHAN * CHAN_W;
    localparam int SIZE_W     = 10;
    localparam int COUNT_W    = 2;
    localparam int SCALE_W    = 25;
    localparam int SCALE_FRAC = 16;
    localparam int PROD_W     = SCALE_W + POS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 3'd4;

    // Request kinds carried in s_tuser.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Neighbourhood slots, in the order the frame store is read.
    localparam logic [1:0] SLOT_P00 = 2'd0;
    localparam logic [1:0] SLOT_P10 = 2'd1;
    localparam logic [1:0] SLOT_P01 = 2'd2;
    localparam logic [1:0] SLOT_P11 = 2'd3;

    localparam logic [CHAN_W-1:0] BYTE_MAX = 8'd255;

    typedef struct packed {
        logic [SIZE_W-1:0]  src_width;
        logic [SIZE_W-1:0]  src_height;
        logic [COUNT_W-1:0] channel_count;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
    } cfg_t;

    typedef struct packed {
        logic       issue;
        logic [1:0] slot;
    } rd_tag_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } lane_ctl_t;

endpackage

>>> rtl/bilinear_image_resize_unit.sv
// A compute request's result reaches m_tdata through the frame-store read and the gather,
// lane and output registers, and waits there while the output side is stalled.
// A compute request closes the input for its scale multiply, coordinate map and four reads
// of the single-port frame store (the first waits for gather_free); a load does not.
// Reset: aresetn is synchronous and active low; it empties the pipeline and restores the
// register defaults. The frame store is not cleared and must be loaded before it is read.
module bilinear_image_resize_unit #(
    parameter int MAX_WIDTH        = 512,
    parameter int MAX_HEIGHT       = 512,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tuser: cmd [0]
    input  logic [0:0]                        s_tuser,
    // s_tdata: pos_x [8:0], pos_y [17:9], in_chan0 [25:18], in_chan1 [33:26],
    //          in_chan2 [41:34], zero padding [47:42]
    input  logic [bir_pkg::S_TDATA_W-1:0]     s_tdata,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: out_chan0 [7:0], out_chan1 [15:8], out_chan2 [23:16]
    output logic [bir_pkg::M_TDATA_W-1:0]     m_tdata,
    // Register write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bir_pkg::SCALE_W-1:0]       cfg_data
);
    import bir_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WF = WEIGHT_FRAC_BITS;
    localparam int MW = 2 * WF + 11;
    localparam int HW = MW - 2 * WF;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index beyond the
    // register list is dropped.
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width     <= SIZE_W'(512);
            cfg_reg.src_height    <= SIZE_W'(512);
            cfg_reg.channel_count <= COUNT_W'(3);
            cfg_reg.scale_x       <= SCALE_W'(65536);
            cfg_reg.scale_y       <= SCALE_W'(65536);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SRC_WIDTH:     cfg_reg.src_width     <= cfg_data[SIZE_W-1:0];
                REG_SRC_HEIGHT:    cfg_reg.src_height    <= cfg_data[SIZE_W-1:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[COUNT_W-1:0];
                REG_SCALE_X:       cfg_reg.scale_x       <= cfg_data;
                REG_SCALE_Y:       cfg_reg.scale_y       <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front end: the sequencer takes requests, maps the destination
    // coordinate and drives the frame store, one access per cycle.
    // ------------------------------------------------------------------
    logic             ram_en, ram_we;
    logic [AW-1:0]    ram_addr;
    logic [PIXEL_W-1:0] ram_wdata, ram_rdata;
    rd_tag_t          rd_tag, rtag_reg;
    logic [WF-1:0]    seq_wx, seq_wy;
    logic             gather_free;

    bir_seq #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .gather_free (gather_free),
        .ram_en      (ram_en),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .rd_tag      (rd_tag),
        .wx          (seq_wx),
        .wy          (seq_wy)
    );

    bir_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_frame_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Pipeline occupancy. Each stage holds one request and moves on when the
    // stage after it is empty or emptying, so a stalled result does not stop
    // the stages behind it from filling.
    // ------------------------------------------------------------------
    logic gv_reg, av_reg, bv_reg, m_tvalid_reg;
    logic o_free, a_free, g_free;
    logic g_move, a_move, b_move;
    logic gather_done;
    lane_ctl_t lane_ctl;

    assign o_free      = !m_tvalid_reg || m_tready;
    assign b_move      = bv_reg && o_free;
    assign a_free      = !bv_reg || o_free;
    assign a_move      = av_reg && a_free;
    assign g_free      = !av_reg || a_free;
    assign g_move      = gv_reg && g_free;
    assign gather_free = !gv_reg || g_move;
    assign gather_done = rtag_reg.issue && (rtag_reg.slot == SLOT_P11);

    assign lane_ctl = '{load_a: g_move, load_b: a_move};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rtag_reg     <= '0;
            gv_reg       <= 1'b0;
            av_reg       <= 1'b0;
            bv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rtag_reg     <= rd_tag;
            gv_reg       <= gather_done || (gv_reg && !g_move);
            av_reg       <= g_move || (av_reg && !a_move);
            bv_reg       <= a_move || (bv_reg && !b_move);
            m_tvalid_reg <= b_move || (m_tvalid_reg && !m_tready);
        end
    end

    // ------------------------------------------------------------------
    // Gather stage. Read data comes back in the cycle after its address; the
    // returned tag says which neighbour it is. The weights are taken with the
    // last neighbour, before the sequencer can map the next request.
    // ------------------------------------------------------------------
    logic [PIXEL_W-1:0] pix_reg [4];
    logic [WF-1:0]      gwx_reg, gwy_reg;

    always_ff @(posedge aclk) begin
        if (rtag_reg.issue) begin
            pix_reg[rtag_reg.slot] <= ram_rdata;
        end
        if (gather_done) begin
            gwx_reg <= seq_wx;
            gwy_reg <= seq_wy;
        end
    end

    // ------------------------------------------------------------------
    // One interpolation lane per channel, all working on the same request.
    // ------------------------------------------------------------------
    logic signed [MW-1:0] lane_acc [NUM_CHAN];

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        bir_lane #(.WF(WF)) u_lane (
            .aclk (aclk),
            .ctl  (lane_ctl),
            .p00  (pix_reg[SLOT_P00][c*CHAN_W +: CHAN_W]),
            .p10  (pix_reg[SLOT_P10][c*CHAN_W +: CHAN_W]),
            .p01  (pix_reg[SLOT_P01][c*CHAN_W +: CHAN_W]),
            .p11  (pix_reg[SLOT_P11][c*CHAN_W +: CHAN_W]),
            .wx   (gwx_reg),
            .wy   (gwy_reg),
            .acc  (lane_acc[c])
        );
    end

    // ------------------------------------------------------------------
    // Merge stage. Each lane's sum is scaled down, clamped to a byte and
    // zeroed when its channel is not in use; the three bytes are packed into
    // the output register. A channel count of zero behaves as one.
    // ------------------------------------------------------------------
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [COUNT_W-1:0]   nch;

    assign nch = (cfg_reg.channel_count == '0) ? COUNT_W'(1) : cfg_reg.channel_count;

    always_comb begin
        logic [HW-1:0]     hi;
        logic [CHAN_W-1:0] val;
        m_tdata_next = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            hi = lane_acc[c][MW-1:2*WF];
            if (lane_acc[c][MW-1]) begin
                val = '0;
            end else if (hi > HW'(BYTE_MAX)) begin
                val = BYTE_MAX;
            end else begin
                val = hi[CHAN_W-1:0];
            end
            if (COUNT_W'(c) >= nch) begin
                val = '0;
            end
            m_tdata_next[c*CHAN_W +: CHAN_W] = val;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/bir_ram.sv
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bir_axis_map.sv
module bir_axis_map #(
    parameter int MAX_SIZE = 512,
    parameter int WF       = 16
) (
    input  logic [bir_pkg::PROD_W-1:0] prod,
    input  logic [bir_pkg::SIZE_W-1:0] size_cfg,
    output logic [$clog2(MAX_SIZE)-1:0] c0,
    output logic [$clog2(MAX_SIZE)-1:0] c1,
    output logic [WF-1:0]               weight
);
    import bir_pkg::*;

    localparam int CW   = $clog2(MAX_SIZE);
    localparam int IPW  = PROD_W - SCALE_FRAC;
    localparam int SZW  = ($clog2(MAX_SIZE + 1) > SIZE_W) ? $clog2(MAX_SIZE + 1) : SIZE_W;
    localparam int CMPW = (IPW > SZW) ? IPW : SZW;

    logic [SZW-1:0]           size_sat;
    logic [SZW-1:0]           last;
    logic [SZW-1:0]           c0_full;
    logic [SZW-1:0]           c0_inc;
    logic [SZW-1:0]           c1_full;
    logic [IPW-1:0]           ip;
    logic [SCALE_FRAC-1:0]    frac_sel;
    logic [SCALE_FRAC+WF-1:0] frac_wide;

    always_comb begin
        if (size_cfg == '0) begin
            size_sat = SZW'(1);
        end else if (SZW'(size_cfg) > SZW'(MAX_SIZE)) begin
            size_sat = SZW'(MAX_SIZE);
        end else begin
            size_sat = SZW'(size_cfg);
        end
        last = size_sat - SZW'(1);
        ip   = prod[PROD_W-1:SCALE_FRAC];

        // Past the last column or row the corner saturates with zero fraction.
        if (CMPW'(ip) > CMPW'(last)) begin
            c0_full  = last;
            frac_sel = '0;
        end else begin
            c0_full  = SZW'(ip);
            frac_sel = prod[SCALE_FRAC-1:0];
        end
        c0_inc  = c0_full + SZW'(1);
        c1_full = (c0_inc < size_sat) ? c0_inc : last;

        // Rescale the Q16 fraction to the weight format.
        frac_wide = {frac_sel, {WF{1'b0}}};
    end

    assign c0     = c0_full[CW-1:0];
    assign c1     = c1_full[CW-1:0];
    assign weight = frac_wide[SCALE_FRAC+WF-1:SCALE_FRAC];

endmodule

>>> rtl/bir_seq.sv
module bir_seq #(
    parameter int MAX_WIDTH        = 512,
    parameter int MAX_HEIGHT       = 512,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bir_pkg::cfg_t                          cfg,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [0:0]                             s_tuser,
    input  logic [bir_pkg::S_TDATA_W-1:0]          s_tdata,
    input  logic                                   gather_free,
    output logic                                   ram_en,
    output logic                                   ram_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] ram_addr,
    output logic [bir_pkg::PIXEL_W-1:0]            ram_wdata,
    output bir_pkg::rd_tag_t                       rd_tag,
    output logic [WEIGHT_FRAC_BITS-1:0]            wx,
    output logic [WEIGHT_FRAC_BITS-1:0]            wy
);
    import bir_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CXW = $clog2(MAX_WIDTH);
    localparam int CYW = $clog2(MAX_HEIGHT);
    localparam int WF  = WEIGHT_FRAC_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_RD0  = 3'd2;
    localparam logic [2:0] ST_RD1  = 3'd3;
    localparam logic [2:0] ST_RD2  = 3'd4;
    localparam logic [2:0] ST_RD3  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [PROD_W-1:0] prod_x_reg, prod_x_next;
    logic [PROD_W-1:0] prod_y_reg, prod_y_next;
    logic [CXW-1:0]    x0_reg, x1_reg, map_x0, map_x1;
    logic [CYW-1:0]    y0_reg, y1_reg, map_y0, map_y1;
    logic [WF-1:0]     wx_reg, wy_reg, map_wx, map_wy;
    logic              accept;
    logic              cmd;
    logic              in_range;
    logic [POS_W-1:0]  pos_x, pos_y;
    logic [AW-1:0]     load_addr;

    function automatic logic [AW-1:0] pix_addr(input logic [CXW-1:0] x,
                                               input logic [CYW-1:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    assign cmd      = s_tuser[0];
    assign pos_x    = s_tdata[POS_W-1:0];
    assign pos_y    = s_tdata[2*POS_W-1:POS_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_range = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
    assign load_addr = AW'(pos_y) * AW'(MAX_WIDTH) + AW'(pos_x);

    assign prod_x_next = PROD_W'(cfg.scale_x) * PROD_W'(pos_x);
    assign prod_y_next = PROD_W'(cfg.scale_y) * PROD_W'(pos_y);

    bir_axis_map #(.MAX_SIZE(MAX_WIDTH), .WF(WF)) u_map_x (
        .prod     (prod_x_reg),
        .size_cfg (cfg.src_width),
        .c0       (map_x0),
        .c1       (map_x1),
        .weight   (map_wx)
    );

    bir_axis_map #(.MAX_SIZE(MAX_HEIGHT), .WF(WF)) u_map_y (
        .prod     (prod_y_reg),
        .size_cfg (cfg.src_height),
        .c0       (map_y0),
        .c1       (map_y1),
        .weight   (map_wy)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && cmd == CMD_COMPUTE) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: state_next = ST_RD0;
            ST_RD0: begin
                if (gather_free) begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1: state_next = ST_RD2;
            ST_RD2: state_next = ST_RD3;
            ST_RD3: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // One frame-store access a cycle: a load write or one neighbour read.
    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = load_addr;
        ram_wdata = s_tdata[2*POS_W +: PIXEL_W];
        rd_tag    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && cmd == CMD_LOAD && in_range) begin
                    ram_en = 1'b1;
                    ram_we = 1'b1;
                end
            end
            ST_RD0: begin
                if (gather_free) begin
                    ram_en   = 1'b1;
                    ram_addr = pix_addr(x0_reg, y0_reg);
                    rd_tag   = '{issue: 1'b1, slot: SLOT_P00};
                end
            end
            ST_RD1: begin
                ram_en   = 1'b1;
                ram_addr = pix_addr(x1_reg, y0_reg);
                rd_tag   = '{issue: 1'b1, slot: SLOT_P10};
            end
            ST_RD2: begin
                ram_en   = 1'b1;
                ram_addr = pix_addr(x0_reg, y1_reg);
                rd_tag   = '{issue: 1'b1, slot: SLOT_P01};
            end
            ST_RD3: begin
                ram_en   = 1'b1;
                ram_addr = pix_addr(x1_reg, y1_reg);
                rd_tag   = '{issue: 1'b1, slot: SLOT_P11};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && cmd == CMD_COMPUTE) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (state_reg == ST_MAP) begin
            x0_reg <= map_x0;
            x1_reg <= map_x1;
            y0_reg <= map_y0;
            y1_reg <= map_y1;
            wx_reg <= map_wx;
            wy_reg <= map_wy;
        end
    end

    assign wx = wx_reg;
    assign wy = wy_reg;

endmodule

>>> rtl/bir_lane.sv
module bir_lane #(
    parameter int WF = 16
) (
    input  logic                          aclk,
    input  bir_pkg::lane_ctl_t            ctl,
    input  logic [bir_pkg::CHAN_W-1:0]    p00,
    input  logic [bir_pkg::CHAN_W-1:0]    p10,
    input  logic [bir_pkg::CHAN_W-1:0]    p01,
    input  logic [bir_pkg::CHAN_W-1:0]    p11,
    input  logic [WF-1:0]                 wx,
    input  logic [WF-1:0]                 wy,
    output logic signed [2*WF+10:0]       acc
);
    import bir_pkg::*;

    localparam int TW = WF + 10;
    localparam int MW = 2 * WF + 11;
    localparam logic signed [MW-1:0] HALF = MW'(1) <<< (2 * WF - 1);

    logic signed [CHAN_W:0] d_top, d_bot;
    logic signed [WF:0]     wx_s, wy_s;
    logic signed [TW-1:0]   prod_top, prod_bot;
    logic signed [TW-1:0]   top_next, bot_next;
    logic signed [TW-1:0]   top_reg, bot_reg;
    logic [WF-1:0]          wy_a_reg;
    logic signed [TW-1:0]   d_vert;
    logic signed [MW-1:0]   prod_vert;
    logic signed [MW-1:0]   top_ext;
    logic signed [MW-1:0]   acc_next, acc_reg;

    // Horizontal blend of the upper and lower row pairs.
    assign d_top    = $signed({1'b0, p10}) - $signed({1'b0, p00});
    assign d_bot    = $signed({1'b0, p11}) - $signed({1'b0, p01});
    assign wx_s     = $signed({1'b0, wx});
    assign prod_top = TW'(wx_s) * TW'(d_top);
    assign prod_bot = TW'(wx_s) * TW'(d_bot);
    assign top_next = $signed({2'b00, p00, {WF{1'b0}}}) + prod_top;
    assign bot_next = $signed({2'b00, p01, {WF{1'b0}}}) + prod_bot;

    // Vertical blend with the rounding half folded in.
    assign d_vert    = bot_reg - top_reg;
    assign wy_s      = $signed({1'b0, wy_a_reg});
    assign prod_vert = MW'(wy_s) * MW'(d_vert);
    assign top_ext   = MW'(top_reg);
    assign acc_next  = prod_vert + (top_ext <<< WF) + HALF;

    always_ff @(posedge aclk) begin
        if (ctl.load_a) begin
            top_reg  <= top_next;
            bot_reg  <= bot_next;
            wy_a_reg <= wy;
        end
        if (ctl.load_b) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/bir_checker.sv
module bir_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bir_pkg::M_TDATA_W-1:0] m_tdata
);
    import bir_pkg::*;

    // After reset no result is pending and requests are taken.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("result pending or input blocked after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A compute request keeps the input closed while it maps and reads its
    // four neighbours.
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == CMD_COMPUTE) |=>
            !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("compute request released the input too early");

    // A load is a single write, so the input stays open.
    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == CMD_LOAD) |=> s_tready)
        else $error("load request blocked the input");

endmodule

bind bilinear_image_resize_unit bir_checker u_bir_checker (.*);
